/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Every macro samples on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CESC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Also checked while reset is applied.
`define CESC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/cesc_pkg.sv */
// Shared types and constants of the charger enable and status controller.
// Used by the register block, datapath, controller and top level.
package cesc_pkg;

    localparam int MAX_PROFILES   = 8;
    localparam int TABLE_PROFILES = 8;
    localparam int PROF_CAP       = (MAX_PROFILES < TABLE_PROFILES) ?
                                    MAX_PROFILES : TABLE_PROFILES;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [3:0] NO_PROFILE = 4'd8;
    localparam logic [3:0] WORD_MODE  = 4'd8;

    // Request commands.
    localparam logic [2:0] CMD_CABLE  = 3'd0;
    localparam logic [2:0] CMD_ENABLE = 3'd1;
    localparam logic [2:0] CMD_STATUS = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_TABLE  = 3'd4;

    // Cable events up to resume mean the charger is present.
    localparam logic [2:0] EV_RESUME = 3'd2;

    // Charge states.
    localparam logic [2:0] CS_UNKNOWN      = 3'd0;
    localparam logic [2:0] CS_CHARGING     = 3'd1;
    localparam logic [2:0] CS_FULL         = 3'd2;
    localparam logic [2:0] CS_NOT_CHARGING = 3'd3;
    localparam logic [2:0] CS_DISCHARGING  = 3'd4;

    localparam logic [15:0] MODE_OFF  = 16'd0;
    localparam logic [15:0] MODE_HIGH = 16'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TEMP_OFFSET  = 3'd0;
    localparam logic [2:0] REG_PROFILE_CNT  = 3'd1;
    localparam logic [2:0] REG_CURRENT_LOW  = 3'd2;
    localparam logic [2:0] REG_CURRENT_HIGH = 3'd3;
    localparam logic [2:0] REG_WIRELESS     = 3'd4;

    typedef struct packed {
        logic signed [15:0] temp_offset;
        logic [3:0]         profile_count;
        logic [11:0]        current_low_ma;
        logic [11:0]        current_high_ma;
        logic               wireless_direct;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_MODE,
        ST_DECIDE,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       rd_en;
        logic       rd_mode;
        logic [2:0] rd_prof;
        logic [3:0] rd_word;
        logic       match_init;
        logic       chk_en;
        logic [2:0] chk_k;
        logic       sel_en;
        logic [2:0] sel_prof;
        logic       decide;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       sensors_valid;
        logic [3:0] lim;
        logic       match_final;
        logic       out_free;
    } dp_sts_t;

endpackage

/* rtl/core/cesc_cfg.sv */
// Configuration registers behind the APB-style port.
// Depends on cesc_pkg for the register indexes and the cfg_t bundle.
module cesc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cesc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cesc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cesc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output cesc_pkg::cfg_t                     cfg
);

    cesc_pkg::cfg_t cfg_reg;
    cesc_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                cesc_pkg::REG_TEMP_OFFSET:  cfg_next.temp_offset     = pwdata[15:0];
                cesc_pkg::REG_PROFILE_CNT:  cfg_next.profile_count   = pwdata[3:0];
                cesc_pkg::REG_CURRENT_LOW:  cfg_next.current_low_ma  = pwdata[11:0];
                cesc_pkg::REG_CURRENT_HIGH: cfg_next.current_high_ma = pwdata[11:0];
                cesc_pkg::REG_WIRELESS:     cfg_next.wireless_direct = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            cesc_pkg::REG_TEMP_OFFSET:  prdata = {16'd0, cfg_reg.temp_offset};
            cesc_pkg::REG_PROFILE_CNT:  prdata = {28'd0, cfg_reg.profile_count};
            cesc_pkg::REG_CURRENT_LOW:  prdata = {20'd0, cfg_reg.current_low_ma};
            cesc_pkg::REG_CURRENT_HIGH: prdata = {20'd0, cfg_reg.current_high_ma};
            cesc_pkg::REG_WIRELESS:     prdata = {31'd0, cfg_reg.wireless_direct};
            default:                    prdata = '0;
        endcase
    end

endmodule

/* rtl/core/cesc_dp.sv */
// Datapath: request registers, profile table memory, window compare,
// charger flags and the result register.
// Depends on cesc_pkg for the command and status bundles and the codes.
module cesc_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [cesc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [cesc_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [cesc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  cesc_pkg::cfg_t                     cfg,
    input  cesc_pkg::dp_cmd_t                  cmd,
    output cesc_pkg::dp_sts_t                  sts
);

    // Request payload.
    logic [2:0]         cmd_reg;
    logic [2:0]         ev_reg;
    logic [2:0]         kind_reg;
    logic               en_req_reg;
    logic               done_reg;
    logic               pg_reg;
    logic               wl_reg;
    logic signed [15:0] temp_reg;
    logic [14:0]        mv_reg;
    logic               sv_reg;
    logic [6:0]         taddr_reg;
    logic [15:0]        tword_reg;

    // Profile table and search.
    logic [15:0]        table_mem [128];
    logic [15:0]        rdata_reg;
    logic [6:0]         rd_addr;
    logic signed [16:0] t_reg;
    logic signed [16:0] v_val;
    logic signed [16:0] a_reg;
    logic signed [16:0] b_val;
    logic signed [16:0] win_sum;
    logic signed [16:0] win_diff;
    logic               pair_ok;
    logic               match_reg;
    logic               match_next;

    // Charger flags.
    logic [3:0]  prof_reg,    prof_next;
    logic [2:0]  status_reg,  status_next;
    logic        present_reg, present_next;
    logic        online_reg,  online_next;
    logic        force_reg,   force_next;
    logic        started_reg, started_next;
    logic        end_n_reg,   end_n_next;
    logic        enabled_reg, enabled_next;
    logic        boost_reg,   boost_next;
    logic [2:0]  cable_reg,   cable_next;
    logic [15:0] mode;
    logic        allow;

    // Result register.
    logic                            m_valid_reg;
    logic [cesc_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [11:0]                     cur_ma;
    logic [3:0]                      prof_cap;

    assign prof_cap = 4'(cesc_pkg::PROF_CAP);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_tuser;
            ev_reg     <= s_tdata[2:0];
            kind_reg   <= s_tdata[5:3];
            en_req_reg <= s_tdata[6];
            done_reg   <= s_tdata[7];
            pg_reg     <= s_tdata[8];
            wl_reg     <= s_tdata[9];
            temp_reg   <= s_tdata[25:10];
            mv_reg     <= s_tdata[40:26];
            sv_reg     <= s_tdata[41];
            taddr_reg  <= s_tdata[48:42];
            tword_reg  <= s_tdata[64:49];
        end
        if (cmd.exec) begin
            t_reg <= {temp_reg[15], temp_reg} - {cfg.temp_offset[15], cfg.temp_offset};
        end
    end

    // The mode word of the selected profile sits at word eight.
    assign rd_addr = cmd.rd_mode ? {prof_reg[2:0], cesc_pkg::WORD_MODE}
                                 : {cmd.rd_prof, cmd.rd_word};

    always_ff @(posedge aclk) begin
        if (cmd.exec && (cmd_reg == cesc_pkg::CMD_TABLE)) begin
            table_mem[taddr_reg] <= tword_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    // Words arrive in pairs: a limit, then its hysteresis. The first is held
    // and the second narrows the window before the compare.
    assign v_val    = {2'b00, mv_reg};
    assign b_val    = {rdata_reg[15], rdata_reg};
    assign win_sum  = a_reg + b_val;
    assign win_diff = a_reg - b_val;

    always_comb begin
        case (cmd.chk_k[2:1])
            2'd0:    pair_ok = (t_reg >= win_sum);
            2'd1:    pair_ok = (t_reg <= win_diff);
            2'd2:    pair_ok = (v_val >= win_sum);
            default: pair_ok = (v_val <= win_diff);
        endcase
    end

    always_comb begin
        match_next = match_reg;
        if (cmd.match_init) begin
            match_next = 1'b1;
        end else if (cmd.chk_en && cmd.chk_k[0]) begin
            match_next = match_reg && pair_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.chk_en && !cmd.chk_k[0]) begin
            a_reg <= b_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign mode  = prof_reg[3] ? cesc_pkg::MODE_OFF : rdata_reg;
    assign allow = pg_reg && present_reg && (mode != cesc_pkg::MODE_OFF) && !force_reg;

    always_comb begin
        prof_next    = prof_reg;
        status_next  = status_reg;
        present_next = present_reg;
        online_next  = online_reg;
        force_next   = force_reg;
        started_next = started_reg;
        end_n_next   = end_n_reg;
        enabled_next = enabled_reg;
        boost_next   = boost_reg;
        cable_next   = cable_reg;

        if (cmd.exec) begin
            case (cmd_reg)
                cesc_pkg::CMD_CABLE: begin
                    cable_next = kind_reg;
                    if (ev_reg <= cesc_pkg::EV_RESUME) begin
                        present_next = 1'b1;
                        online_next  = (kind_reg != 3'd0);
                    end else begin
                        present_next = 1'b0;
                        online_next  = 1'b0;
                        started_next = 1'b0;
                    end
                end
                cesc_pkg::CMD_ENABLE: begin
                    force_next = !en_req_reg;
                    if (!en_req_reg) begin
                        enabled_next = 1'b0;
                    end
                end
                cesc_pkg::CMD_STATUS: begin
                    end_n_next = done_reg;
                    if (!done_reg) begin
                        started_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.sel_en) begin
            prof_next = {1'b0, cmd.sel_prof};
        end

        if (cmd.decide) begin
            if (allow) begin
                // Full is only reported once a charge cycle has run to its end.
                if (started_reg && end_n_reg &&
                    ((status_reg == cesc_pkg::CS_CHARGING) ||
                     (status_reg == cesc_pkg::CS_FULL))) begin
                    status_next = cesc_pkg::CS_FULL;
                end else begin
                    status_next = cesc_pkg::CS_CHARGING;
                end
                enabled_next = 1'b1;
            end else begin
                enabled_next = 1'b0;
                status_next  = pg_reg ? cesc_pkg::CS_NOT_CHARGING
                                      : cesc_pkg::CS_DISCHARGING;
                if (cfg.wireless_direct && wl_reg && !pg_reg) begin
                    status_next = cesc_pkg::CS_CHARGING;
                end
            end
            boost_next = (mode == cesc_pkg::MODE_HIGH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prof_reg    <= cesc_pkg::NO_PROFILE;
            status_reg  <= cesc_pkg::CS_UNKNOWN;
            present_reg <= 1'b0;
            online_reg  <= 1'b0;
            force_reg   <= 1'b0;
            started_reg <= 1'b0;
            end_n_reg   <= 1'b0;
            enabled_reg <= 1'b0;
            boost_reg   <= 1'b0;
            cable_reg   <= 3'd0;
        end else begin
            prof_reg    <= prof_next;
            status_reg  <= status_next;
            present_reg <= present_next;
            online_reg  <= online_next;
            force_reg   <= force_next;
            started_reg <= started_next;
            end_n_reg   <= end_n_next;
            enabled_reg <= enabled_next;
            boost_reg   <= boost_next;
            cable_reg   <= cable_next;
        end
    end

    assign cur_ma = enabled_reg ? (boost_reg ? cfg.current_high_ma : cfg.current_low_ma)
                                : 12'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {6'd0, prof_reg, cable_reg, present_reg, online_reg,
                           cur_ma, boost_reg, enabled_reg, status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        sts.cmd           = cmd_reg;
        sts.sensors_valid = sv_reg;
        sts.lim           = (cfg.profile_count > prof_cap) ? prof_cap : cfg.profile_count;
        sts.match_final   = match_reg && pair_ok;
        sts.out_free      = !m_valid_reg || m_tready;
    end

endmodule

/* rtl/core/cesc_ctrl.sv */
// Controller state machine: sequences the event update, the profile search,
// the mode read, the decision and the result hand-off.
// Depends on cesc_pkg for the state type and the command and status bundles.
module cesc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  cesc_pkg::dp_sts_t     sts,
    output cesc_pkg::dp_cmd_t     cmd
);

    cesc_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0] prof_reg, prof_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] prof_inc;
    logic [2:0] step_k;
    logic [2:0] chk_k;

    assign prof_inc = prof_reg + 4'd1;
    assign step_k   = step_reg[2:0];
    assign chk_k    = step_k - 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cesc_pkg::ST_IDLE;
            prof_reg  <= 4'd0;
            step_reg  <= 4'd0;
        end else begin
            state_reg <= state_next;
            prof_reg  <= prof_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        prof_next  = prof_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;

        case (state_reg)
            cesc_pkg::ST_IDLE: begin
                // No request is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = cesc_pkg::ST_EXEC;
                end
            end
            cesc_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.cmd > cesc_pkg::CMD_TICK) begin
                    state_next = cesc_pkg::ST_DONE;
                end else if (sts.sensors_valid && (sts.lim != 4'd0)) begin
                    prof_next  = 4'd0;
                    step_next  = 4'd0;
                    state_next = cesc_pkg::ST_SEARCH;
                end else begin
                    state_next = cesc_pkg::ST_MODE;
                end
            end
            cesc_pkg::ST_SEARCH: begin
                // Reads go out in steps 0 to 7 and are checked in steps 1 to 8, once registered.
                // Word order pairs each limit with its hysteresis.
                cmd.rd_prof    = prof_reg[2:0];
                cmd.rd_word    = {1'b0, step_k[0], step_k[2:1]};
                cmd.rd_en      = !step_reg[3];
                cmd.match_init = (step_reg == 4'd0);
                cmd.chk_en     = (step_reg != 4'd0);
                cmd.chk_k      = chk_k;
                if (step_reg[3]) begin
                    step_next = 4'd0;
                    if (sts.match_final) begin
                        cmd.sel_en   = 1'b1;
                        cmd.sel_prof = prof_reg[2:0];
                        state_next   = cesc_pkg::ST_MODE;
                    end else if (prof_inc < sts.lim) begin
                        prof_next = prof_inc;
                    end else begin
                        state_next = cesc_pkg::ST_MODE;
                    end
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            cesc_pkg::ST_MODE: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = 1'b1;
                state_next  = cesc_pkg::ST_DECIDE;
            end
            cesc_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = cesc_pkg::ST_DONE;
            end
            cesc_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = cesc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cesc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/charger_enable_status_controller.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = cmd, s_tdata = event and sensor fields
// m_*       out  m_tvalid/m_tready  m_tdata = charge state and flags, one per request
// apb       in   psel/penable       five configuration registers, pready always high
//
// Table writes and unused codes pass the execute and final steps to the result
// register; the other requests add the mode read and the decision, after a search
// of n profiles (0 to 8) paced by the table's single read port (one word per cycle).
// Reset (aresetn low at a clock edge) clears flags and selection; the table is
// not cleared and holds nothing meaningful until software writes it.
// A stalled result holds its register; the next request is accepted meanwhile and
// waits in the final step until the result register frees.
// Top level of the charger enable and status controller; uses cesc_pkg,
// cesc_cfg, cesc_dp and cesc_ctrl.
module charger_enable_status_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] cable_event, [5:3] cable_kind, [6] enable_request, [7] done_flag_n,
    // [8] power_good, [9] wireless_online, [25:10] battery_temp,
    // [40:26] battery_mv, [41] sensors_valid, [48:42] table_address,
    // [64:49] table_word, [71:65] zero
    input  logic [cesc_pkg::IN_DATA_W-1:0]     s_tdata,
    // [2:0] cmd
    input  logic [cesc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] charge_state, [3] charge_enable, [4] boost_rate,
    // [16:5] charge_current_ma, [17] source_online, [18] charger_present,
    // [21:19] cable_kind_out, [25:22] profile_index, [31:26] zero
    output logic [cesc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cesc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cesc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cesc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    cesc_pkg::cfg_t    cfg;
    cesc_pkg::dp_cmd_t dp_cmd;
    cesc_pkg::dp_sts_t dp_sts;

    cesc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cesc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cfg      (cfg),
        .cmd      (dp_cmd),
        .sts      (dp_sts)
    );

    cesc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

endmodule

/* rtl/core/cesc_checker.sv */
// Port-level checks of the charger enable and status controller, bound to
// the top level. Uses the macros of assert_macros.svh.
`include "assert_macros.svh"

module cesc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result keeps its value.
    `CESC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Nothing is offered straight out of reset.
    `CESC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

    // One request is worked at a time, so the input closes after acceptance.
    `CESC_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second request taken while busy")

    // No current is reported while charging is disabled.
    `CESC_ASSERT(a_no_current_off, m_tvalid && !m_tdata[3] |-> m_tdata[16:5] == 12'd0, "current reported with charging off")

    // The selected profile is a table slot or the none marker.
    `CESC_ASSERT(a_profile_range, m_tvalid |-> m_tdata[25:22] <= 4'd8, "profile index out of range")

endmodule

bind charger_enable_status_controller cesc_checker u_cesc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/charger_enable_status_controller_checker.sv */
// Checker for the charger enable and status controller: predicts every result from the
// requests and register writes it observes, then compares field by field.
// Depends on cesc_pkg for widths, command, state and register codes.
module charger_enable_status_controller_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [cesc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [cesc_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cesc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [cesc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cesc_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                 failures,
    output int                                 pending,
    output int                                 results_checked
);
    import cesc_pkg::*;

    typedef struct packed {
        logic [2:0]  charge_state;
        logic        charge_enable;
        logic        boost_rate;
        logic [11:0] current_ma;
        logic        source_online;
        logic        charger_present;
        logic [2:0]  cable_kind;
        logic [3:0]  profile_index;
    } charge_report_t;

    // Shadow of the profile table and the configuration registers.
    logic [15:0]        prof_words [128];
    logic signed [15:0] offset_q;
    logic [3:0]         count_q;
    logic [11:0]        low_ma_q;
    logic [11:0]        high_ma_q;
    logic               wireless_q;

    // Shadow of the supervisor state.
    logic [3:0] sel_profile;
    logic [2:0] charge_state_q;
    logic [2:0] cable_q;
    logic       present_q;
    logic       online_q;
    logic       force_off_q;
    logic       started_q;
    logic       end_n_q;
    logic       enabled_q;
    logic       boost_q;

    charge_report_t expected_reports [$];

    initial begin
        failures        = 0;
        pending         = 0;
        results_checked = 0;
    end

    function automatic int prof_word(int prof, int w);
        return int'($signed(prof_words[prof * 16 + w]));
    endfunction

    // First profile whose window, narrowed by its hysteresis, holds t and v wins.
    task automatic find_profile(input int t, input int v);
        int lim;
        lim = (count_q > PROF_CAP) ? PROF_CAP : int'(count_q);
        for (int i = 0; i < lim; i++) begin
            if (t >= prof_word(i, 0) + prof_word(i, 4) &&
                t <= prof_word(i, 1) - prof_word(i, 5) &&
                v >= prof_word(i, 2) + prof_word(i, 6) &&
                v <= prof_word(i, 3) - prof_word(i, 7)) begin
                sel_profile = 4'(i);
                return;
            end
        end
    endtask

    task automatic update_charge(input logic [IN_DATA_W-1:0] d);
        logic pgood;
        int   mode;
        pgood = d[8];
        if (d[41])
            find_profile(int'($signed(d[25:10])) - int'(offset_q), int'(d[40:26]));
        mode = (sel_profile >= TABLE_PROFILES) ? 0 : prof_word(int'(sel_profile), int'(WORD_MODE));
        if (pgood && present_q && mode != int'(MODE_OFF) && !force_off_q) begin
            if (started_q && end_n_q &&
                (charge_state_q == CS_CHARGING || charge_state_q == CS_FULL))
                charge_state_q = CS_FULL;
            else
                charge_state_q = CS_CHARGING;
            enabled_q = 1'b1;
        end else begin
            enabled_q = 1'b0;
            charge_state_q = pgood ? CS_NOT_CHARGING : CS_DISCHARGING;
            // A wireless charger may report charging without power good.
            if (wireless_q && d[9] && !pgood)
                charge_state_q = CS_CHARGING;
        end
        boost_q = (mode == int'(MODE_HIGH));
    endtask

    task automatic predict_request(input logic [2:0] cmd, input logic [IN_DATA_W-1:0] d);
        charge_report_t r;
        case (cmd)
            CMD_CABLE: begin
                cable_q = d[5:3];
                if (d[2:0] <= EV_RESUME) begin
                    present_q = 1'b1;
                    online_q  = (cable_q != 3'd0);
                end else begin
                    present_q = 1'b0;
                    online_q  = 1'b0;
                    started_q = 1'b0;
                end
                update_charge(d);
            end
            CMD_ENABLE: begin
                force_off_q = !d[6];
                if (force_off_q)
                    enabled_q = 1'b0;
                update_charge(d);
            end
            CMD_STATUS: begin
                end_n_q = d[7];
                if (!end_n_q)
                    started_q = 1'b1;
                update_charge(d);
            end
            CMD_TICK: begin
                update_charge(d);
            end
            CMD_TABLE: begin
                prof_words[d[48:42]] = d[64:49];
            end
            default: ;
        endcase
        r.charge_state    = charge_state_q;
        r.charge_enable   = enabled_q;
        r.boost_rate      = boost_q;
        r.current_ma      = enabled_q ? (boost_q ? high_ma_q : low_ma_q) : 12'd0;
        r.source_online   = online_q;
        r.charger_present = present_q;
        r.cable_kind      = cable_q;
        r.profile_index   = sel_profile;
        expected_reports.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (failures < 40)
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     results_checked, what, got, want);
        failures++;
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] q);
        charge_report_t want;
        if (expected_reports.size() == 0) begin
            report_mismatch("result with no request outstanding", int'(q), -1);
            return;
        end
        want = expected_reports.pop_front();
        if (q[2:0] != want.charge_state)
            report_mismatch("charge_state", q[2:0], want.charge_state);
        if (q[3] != want.charge_enable)
            report_mismatch("charge_enable", q[3], want.charge_enable);
        if (q[4] != want.boost_rate)
            report_mismatch("boost_rate", q[4], want.boost_rate);
        if (q[16:5] != want.current_ma)
            report_mismatch("charge_current_ma", q[16:5], want.current_ma);
        if (q[17] != want.source_online)
            report_mismatch("source_online", q[17], want.source_online);
        if (q[18] != want.charger_present)
            report_mismatch("charger_present", q[18], want.charger_present);
        if (q[21:19] != want.cable_kind)
            report_mismatch("cable_kind_out", q[21:19], want.cable_kind);
        if (q[25:22] != want.profile_index)
            report_mismatch("profile_index", q[25:22], want.profile_index);
        results_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            offset_q       = '0;
            count_q        = '0;
            low_ma_q       = '0;
            high_ma_q      = '0;
            wireless_q     = 1'b0;
            sel_profile    = NO_PROFILE;
            charge_state_q = CS_UNKNOWN;
            cable_q        = '0;
            present_q      = 1'b0;
            online_q       = 1'b0;
            force_off_q    = 1'b0;
            started_q      = 1'b0;
            end_n_q        = 1'b0;
            enabled_q      = 1'b0;
            boost_q        = 1'b0;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TEMP_OFFSET:  offset_q   = pwdata[15:0];
                    REG_PROFILE_CNT:  count_q    = pwdata[3:0];
                    REG_CURRENT_LOW:  low_ma_q   = pwdata[11:0];
                    REG_CURRENT_HIGH: high_ma_q  = pwdata[11:0];
                    REG_WIRELESS:     wireless_q = pwdata[0];
                    default: ;
                endcase
            end
            // A result always belongs to an earlier request, so compare before predicting.
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
        end
        pending = expected_reports.size();
    end

endmodule

/* bench/charger_enable_status_controller_tb.sv */
// Top of the charger enable and status controller bench: clock, reset, register writes,
// directed and random requests with idling on both channels, and the verdict.
// Depends on cesc_pkg, the block itself and charger_enable_status_controller_checker.
module charger_enable_status_controller_tb;
    import cesc_pkg::*;

    localparam int ITEMS_PER_PHASE = 170;
    localparam int RANDOM_PHASES   = 7;
    localparam int SETTLE_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  ev;
        logic [2:0]  kind;
        logic        en;
        logic        done_n;
        logic        pgood;
        logic        wl;
        logic [15:0] temp;
        logic [14:0] mv;
        logic        valid;
        logic [6:0]  addr;
        logic [15:0] word;
    } charger_request_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata  = '0;
    logic [IN_USER_W-1:0]    s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int failures;
    int pending;
    int results_checked;

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left  = 0;
    int idle_cycles = 0;
    int offset_now  = 0;
    int settings_applied = 0;
    int cmd_seen [8];

    always #5 aclk = ~aclk;

    charger_enable_status_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    charger_enable_status_controller_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Result side back-pressure in bursts of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
                $display("charger_enable_status_controller_tb failed");
                $finish;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(charger_request_t r);
        return {7'd0, r.word, r.addr, r.valid, r.mv, r.temp,
                r.wl, r.pgood, r.done_n, r.en, r.kind, r.ev};
    endfunction

    function automatic charger_request_t make_request(
        logic [2:0] cmd, logic [2:0] ev, logic [2:0] kind, logic en, logic done_n,
        logic pgood, logic wl, logic [15:0] temp, logic [14:0] mv, logic valid);
        charger_request_t r;
        r.cmd = cmd;   r.ev = ev;       r.kind = kind;   r.en = en;
        r.done_n = done_n; r.pgood = pgood; r.wl = wl;
        r.temp = temp; r.mv = mv;       r.valid = valid;
        r.addr = '0;   r.word = '0;
        return r;
    endfunction

    // Plausible contents for a profile word, so that windows overlap the sensor readings.
    function automatic logic [15:0] table_value(int w);
        case (w)
            0: return 16'(int'($urandom_range(0, 300)) - 200);
            1: return 16'(int'($urandom_range(150, 500)));
            2: return 16'(int'($urandom_range(2800, 3600)));
            3: return 16'(int'($urandom_range(3800, 4700)));
            4, 5, 6, 7: begin
                if ($urandom_range(0, 9) == 0)
                    return 16'(-int'($urandom_range(0, 10)));
                return 16'($urandom_range(0, 30));
            end
            8: begin
                if ($urandom_range(0, 4) == 0)
                    return 16'($urandom);
                return 16'($urandom_range(0, 3));
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic charger_request_t random_request();
        charger_request_t r;
        int pick;
        int w;
        pick = $urandom_range(0, 99);
        r.cmd = (pick < 18) ? CMD_CABLE  :
                (pick < 32) ? CMD_ENABLE :
                (pick < 50) ? CMD_STATUS :
                (pick < 88) ? CMD_TICK   :
                (pick < 97) ? CMD_TABLE  : 3'($urandom_range(5, 7));
        r.ev     = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 2))
                                              : 3'($urandom_range(3, 7));
        r.kind   = 3'($urandom);
        r.en     = ($urandom_range(0, 9) < 8);
        r.done_n = 1'($urandom);
        r.pgood  = ($urandom_range(0, 9) < 8);
        r.wl     = 1'($urandom);
        r.valid  = ($urandom_range(0, 19) < 17);
        if ($urandom_range(0, 9) == 0) begin
            r.temp = 16'($urandom);
            r.mv   = 15'($urandom);
        end else begin
            r.temp = 16'(offset_now + int'($urandom_range(0, 900)) - 400);
            r.mv   = 15'($urandom_range(2800, 4800));
        end
        r.addr = 7'($urandom);
        r.word = 16'($urandom);
        if (r.cmd == CMD_TABLE) begin
            if ($urandom_range(0, 2) != 0) begin
                w = $urandom_range(0, 15);
                r.addr = 7'(((w < 8) ? $urandom_range(0, 6) : $urandom_range(0, 7)) * 16 + w);
                r.word = table_value(w);
            end else if (r.addr[6:4] == 3'd7 && !r.addr[3]) begin
                // Profile 7 keeps its catch-all window for the whole run.
                r.addr[3] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_request(input charger_request_t r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= pack_request(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmd_seen[r.cmd]++;
    endtask

    task automatic write_table(input logic [6:0] addr, input logic [15:0] word);
        charger_request_t r;
        r = make_request(CMD_TABLE, 3'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom), 15'($urandom),
                         1'($urandom));
        r.addr = addr;
        r.word = word;
        send_request(r);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let every outstanding request produce its result, then give the block time to go idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input int offset, input int count, input int low_ma,
                                  input int high_ma, input int wireless);
        settle();
        reg_write(REG_TEMP_OFFSET,  32'(offset & 'hFFFF));
        reg_write(REG_PROFILE_CNT,  32'(count & 'hF));
        reg_write(REG_CURRENT_LOW,  32'(low_ma & 'hFFF));
        reg_write(REG_CURRENT_HIGH, 32'(high_ma & 'hFFF));
        reg_write(REG_WIRELESS,     32'(wireless & 1));
        offset_now = int'($signed(16'(offset)));
        settings_applied++;
    endtask

    // Profile 0 has a known window and the boost mode; profile 7 accepts any reading.
    task automatic load_profiles();
        logic [15:0] word;
        for (int p = 0; p < 8; p++) begin
            for (int w = 0; w < 16; w++) begin
                word = table_value(w);
                if (p == 0 && w < 9) begin
                    case (w)
                        0: word = 16'(-100);
                        1: word = 16'd200;
                        2: word = 16'd3000;
                        3: word = 16'd4200;
                        4: word = 16'd10;
                        5: word = 16'd20;
                        6, 7: word = 16'd5;
                        default: word = MODE_HIGH;
                    endcase
                end else if (p == 7 && w < 9) begin
                    word = (w == 1 || w == 3) ? 16'h7FFF : (w == 8) ? 16'd1 : 16'h8000;
                end
                write_table(7'(p * 16 + w), word);
            end
        end
    endtask

    initial begin
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // No profiles are searched yet, so no table word affects the results.
        apply_settings(0, 0, 300, 2000, 1);
        send_request(make_request(CMD_TICK,   0, 0, 0, 0, 0, 0, 16'd0, 15'd0, 0));
        send_request(make_request(CMD_TICK,   0, 0, 0, 0, 0, 1, 16'd0, 15'd0, 0));
        send_request(make_request(CMD_CABLE,  0, 5, 0, 0, 1, 0, 16'd0, 15'd0, 1));
        send_request(make_request(CMD_ENABLE, 0, 0, 1, 0, 1, 0, 16'd0, 15'd0, 0));
        send_request(make_request(CMD_CABLE,  7, 7, 0, 0, 1, 1, 16'd0, 15'd0, 0));
        send_request(make_request(3'd5,       0, 0, 0, 0, 1, 0, 16'd0, 15'd0, 1));
        send_request(make_request(3'd7,       0, 0, 0, 0, 1, 0, 16'd0, 15'd0, 1));
        send_request(make_request(CMD_ENABLE, 0, 0, 0, 0, 0, 1, 16'd0, 15'd0, 0));
        load_profiles();

        // With the largest offset, t = battery_temp - 32767 runs from -65535 to 0.
        apply_settings(32767, 8, 4095, 1234, 0);
        send_request(make_request(CMD_CABLE,  2, 7, 0, 0, 1, 0, 16'h8000, 15'd0, 1));
        send_request(make_request(CMD_ENABLE, 7, 7, 1, 1, 1, 1, 16'h7FFF, 15'h7FFF, 1));
        send_request(make_request(CMD_STATUS, 0, 0, 1, 0, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_STATUS, 0, 0, 1, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_TICK,   0, 0, 1, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_TICK,   0, 0, 1, 1, 1, 0, 16'h8000, 15'd0, 0));
        // Edges of profile 0: lower bounds inclusive, then one below; the third temperature wraps in 16 bits.
        send_request(make_request(CMD_TICK,   0, 0, 0, 1, 1, 0, 16'(32767 - 90), 15'd3005, 1));
        send_request(make_request(CMD_TICK,   0, 0, 0, 1, 1, 0, 16'(32767 - 91), 15'd3005, 1));
        send_request(make_request(CMD_TICK,   0, 0, 0, 1, 1, 0, 16'(32767 + 180), 15'd4195, 1));
        write_table(7'd8, 16'hFFFF);
        send_request(make_request(CMD_TICK,   0, 0, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        write_table(7'd127, 16'h8000);
        send_request(make_request(CMD_CABLE,  1, 0, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_CABLE,  3, 2, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_CABLE,  4, 2, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_CABLE,  5, 6, 0, 1, 0, 1, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(CMD_ENABLE, 0, 0, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));
        send_request(make_request(3'd6,       0, 0, 0, 1, 1, 0, 16'h7FFF, 15'd3700, 1));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(0, 8, 300, 2000, 0);
                1: apply_settings(-32768, 8, 0, 4095, 1);
                2: apply_settings(32767, 3, 4095, 0, 0);
                3: apply_settings(int'($urandom_range(0, 100)) - 50, 0,
                                  $urandom_range(0, 4095), $urandom_range(0, 4095), 1);
                4: apply_settings(int'($urandom_range(0, 400)) - 200, 15,
                                  $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
                5: apply_settings(-20, 1, 1, 4095, 1);
                default: apply_settings(0, 6, $urandom_range(0, 4095),
                                        $urandom_range(0, 4095), $urandom_range(0, 1));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == RANDOM_PHASES - 1) begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end else if (n % 40 == 0) begin
                    gaps_on   = ($urandom_range(0, 9) < 7);
                    stalls_on = ($urandom_range(0, 9) < 7);
                end
                send_request(random_request());
            end
        end
        settle();

        $display("Run covered %0d requests (%0d cable, %0d enable, %0d status, %0d tick,",
                 cmd_seen.sum(), cmd_seen[CMD_CABLE], cmd_seen[CMD_ENABLE],
                 cmd_seen[CMD_STATUS], cmd_seen[CMD_TICK]);
        $display("%0d table, %0d unused codes) over %0d register settings; %0d results compared.",
                 cmd_seen[CMD_TABLE], cmd_seen[5] + cmd_seen[6] + cmd_seen[7],
                 settings_applied, results_checked);
        if (failures == 0) begin
            $display("charger_enable_status_controller_tb passed");
        end else begin
            $display("charger_enable_status_controller_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cesc_pkg.sv
rtl/core/cesc_cfg.sv
rtl/core/cesc_dp.sv
rtl/core/cesc_ctrl.sv
rtl/core/charger_enable_status_controller.sv
rtl/core/cesc_checker.sv
bench/charger_enable_status_controller_checker.sv
bench/charger_enable_status_controller_tb.sv
